FILE: rtl/wtrs_pkg.sv
// Shared types and codes for the wavelet tree rank/select core.
`default_nettype none
package wtrs_pkg;

    localparam int ANSWER_W = 11;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_BUILD  = 3'd1;
    localparam logic [2:0] OP_ACCESS = 3'd2;
    localparam logic [2:0] OP_RANK   = 3'd3;
    localparam logic [2:0] OP_SELECT = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD       = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [3:0] SYMBOL_BITS_RESET = 4'd8;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  symbol;
        logic [9:0]  position;
        logic [10:0] occurrence;
    } wtrs_in_t;

    typedef struct packed {
        logic [ANSWER_W-1:0] answer;
        logic                found;
        logic [1:0]          status;
    } wtrs_out_t;

    typedef struct packed {
        logic latch;
        logic decode;
        logic scan;
        logic emit;
    } wtrs_cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic scan_done;
        logic out_free;
    } wtrs_stat_t;

endpackage
`default_nettype wire

FILE: rtl/wavelet_tree_rank_select_core.sv
// Top level of the symbol sequence core with access, rank and select queries.
`default_nettype none
// Symbols are appended one beat at a time into a store of MAX_LENGTH entries
// with one write port and one registered read port; a build beat latches the
// symbol width (the symbol_bits register, clamped to 1..MAX_SYMBOL_BITS) and
// marks the sequence as queryable.
// Every input beat produces exactly one result beat. Append and build pass
// from acceptance through decode to the output register; a well-formed
// access, rank or select on a non-empty sequence also passes through the scan
// state. Rank scans positions 0..pos and select scans up to length entries:
// the scan reads one stored symbol per cycle through the store's registered
// read port. One item is worked on at a time; the next beat is taken in the
// cycle after the current result has moved into the output register, even
// while that result still waits for m_ready.
// Write symbol_bits only while no beat is in flight.
module wavelet_tree_rank_select_core import wtrs_pkg::*; #(
    parameter int MAX_LENGTH      = 1024,
    parameter int MAX_SYMBOL_BITS = 8
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire wtrs_in_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output wtrs_out_t       m_data,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_wdata
);

    wtrs_cmd_t  cmd;
    wtrs_stat_t stat;

    // sequence one beat through decode, scan and delivery
    wtrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // hold the store, the scan counters and the output register
    wtrs_datapath #(
        .MAX_LENGTH      (MAX_LENGTH),
        .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

FILE: rtl/wtrs_ctrl.sv
// Sequencer for the wavelet tree core: accept, decode, scan, deliver.
`default_nettype none
module wtrs_ctrl import wtrs_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire wtrs_stat_t stat,
    output wtrs_cmd_t       cmd
);

    typedef enum logic [1:0] {IDLE, DECODE, SCAN, DONE} state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = DECODE;
                end
            end
            DECODE: begin
                cmd.decode = 1'b1;
                state_next = stat.needs_scan ? SCAN : DONE;
            end
            SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = DONE;
                end
            end
            DONE: begin
                // hold the result until the output register frees up
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    assign s_ready = (state_reg == IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/wtrs_datapath.sv
// Symbol store, query scan unit and result registers.
`default_nettype none
module wtrs_datapath import wtrs_pkg::*; #(
    parameter int MAX_LENGTH      = 1024,
    parameter int MAX_SYMBOL_BITS = 8
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire wtrs_in_t   s_data,
    output wtrs_out_t       m_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_wdata,
    input  wire wtrs_cmd_t  cmd,
    output wtrs_stat_t      stat
);

    localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
    localparam int CNT_W  = (LEN_W > ANSWER_W) ? LEN_W : ANSWER_W;

    logic [7:0]       mem [MAX_LENGTH];
    logic [7:0]       q_reg;

    logic [3:0]       sym_bits_reg;
    logic [CNT_W-1:0] len_reg;
    logic             built_reg;
    logic [4:0]       width_reg;
    wtrs_in_t         item_reg;
    logic [CNT_W-1:0] issue_reg, limit_reg, count_reg, rd_idx_reg;
    logic             rd_vld_reg;
    wtrs_out_t        res_reg, out_reg;
    logic             m_valid_reg;

    logic [4:0]       eff_bits;
    logic [7:0]       mask;
    logic [CNT_W-1:0] pos_ext, nth_ext, count_inc;
    logic [1:0]       dec_status;
    logic             dec_scan, append_ok, match, done;
    logic [CNT_W-1:0] wr_idx;

    always_comb begin
        if (sym_bits_reg == 4'd0) begin
            eff_bits = 5'd1;
        end else if (int'(sym_bits_reg) > MAX_SYMBOL_BITS) begin
            eff_bits = 5'(MAX_SYMBOL_BITS);
        end else begin
            eff_bits = {1'b0, sym_bits_reg};
        end
    end

    assign mask      = ~(8'hFF << width_reg);
    assign pos_ext   = CNT_W'(item_reg.position);
    assign nth_ext   = CNT_W'(item_reg.occurrence);
    assign wr_idx    = built_reg ? '0 : len_reg;
    assign match     = ((q_reg & mask) == item_reg.symbol);
    assign count_inc = count_reg + CNT_W'(match);

    // classify the latched item
    always_comb begin
        dec_status = ST_OK;
        dec_scan   = 1'b0;
        unique case (item_reg.operation)
            OP_APPEND: begin
                if ((item_reg.symbol >> eff_bits) != 8'd0) begin
                    dec_status = ST_BAD;
                end else if (!built_reg && len_reg >= CNT_W'(MAX_LENGTH)) begin
                    dec_status = ST_FULL;
                end
            end
            OP_BUILD: dec_status = ST_OK;
            OP_ACCESS, OP_RANK, OP_SELECT: begin
                if (!built_reg) begin
                    dec_status = ST_NOT_BUILT;
                end else if (item_reg.operation == OP_SELECT) begin
                    if (item_reg.occurrence == 11'd0 ||
                        (item_reg.symbol >> width_reg) != 8'd0) begin
                        dec_status = ST_BAD;
                    end else begin
                        dec_scan = (len_reg != '0);
                    end
                end else if (pos_ext >= len_reg ||
                             (item_reg.operation == OP_RANK &&
                              (item_reg.symbol >> width_reg) != 8'd0)) begin
                    dec_status = ST_BAD;
                end else begin
                    dec_scan = 1'b1;
                end
            end
            default: dec_status = ST_BAD;
        endcase
    end

    assign append_ok = (item_reg.operation == OP_APPEND) && (dec_status == ST_OK);

    always_comb begin
        done = 1'b0;
        if (cmd.scan && rd_vld_reg) begin
            case (item_reg.operation)
                OP_ACCESS: done = 1'b1;
                OP_RANK:   done = (rd_idx_reg == pos_ext);
                default:   done = (match && count_inc == nth_ext) ||
                                  (rd_idx_reg == len_reg - 1'b1);
            endcase
        end
    end

    assign stat.needs_scan = dec_scan;
    assign stat.scan_done  = done;
    assign stat.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.decode && append_ok) begin
            mem[wr_idx[ADDR_W-1:0]] <= item_reg.symbol;
        end
        q_reg <= mem[issue_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            item_reg <= s_data;
        end
        if (cmd.decode) begin
            res_reg    <= '{answer: '0, found: 1'b0, status: dec_status};
            issue_reg  <= (item_reg.operation == OP_ACCESS) ? pos_ext : '0;
            limit_reg  <= (item_reg.operation == OP_SELECT) ? len_reg : pos_ext + 1'b1;
            count_reg  <= '0;
        end
        if (cmd.scan) begin
            if (issue_reg < limit_reg) begin
                issue_reg <= issue_reg + 1'b1;
            end
            rd_idx_reg <= issue_reg;
            if (rd_vld_reg) begin
                count_reg <= count_inc;
                case (item_reg.operation)
                    OP_ACCESS: res_reg.answer <= ANSWER_W'(q_reg & mask);
                    OP_RANK:   res_reg.answer <= ANSWER_W'(count_inc);
                    default: begin
                        if (match && count_inc == nth_ext) begin
                            res_reg.answer <= ANSWER_W'(rd_idx_reg);
                            res_reg.found  <= 1'b1;
                        end
                    end
                endcase
            end
        end
        if (cmd.emit) begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_bits_reg <= SYMBOL_BITS_RESET;
            len_reg      <= '0;
            built_reg    <= 1'b0;
            width_reg    <= 5'd1;
            rd_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                sym_bits_reg <= cfg_wdata;
            end
            if (cmd.decode) begin
                rd_vld_reg <= 1'b0;
                if (append_ok) begin
                    len_reg   <= wr_idx + 1'b1;
                    built_reg <= 1'b0;
                end
                if (item_reg.operation == OP_BUILD) begin
                    width_reg <= eff_bits;
                    built_reg <= 1'b1;
                end
            end else if (cmd.scan) begin
                rd_vld_reg <= (issue_reg < limit_reg);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the wavelet tree access/rank/select core.
`default_nettype none
module tb_top;
    import wtrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEQ_DEPTH  = 1024;
    localparam int MAX_WIDTH  = 8;
    localparam int IDLE_LIMIT = 20000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    wtrs_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    wtrs_out_t m_data;
    logic      cfg_we;
    logic [3:0] cfg_wdata;

    wavelet_tree_rank_select_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the sequence store and build state
    // ------------------------------------------------------------------
    logic [7:0] seq_sym [SEQ_DEPTH];
    int         seq_len;
    bit         tree_ready;
    int         tree_width;   // width latched at build
    logic [3:0] width_reg;    // shadow of symbol_bits

    wtrs_out_t  answer_q[$];
    int         mismatches;
    int         idle_cycles;

    function automatic int clamp_width(logic [3:0] r);
        if (r < 1) return 1;
        if (r > MAX_WIDTH) return MAX_WIDTH;
        return int'(r);
    endfunction

    // Apply one beat to the shadow state and return the result it should produce.
    // The tree is a layout detail: access/rank/select answer the same questions
    // over the masked symbol sequence, so count over it directly.
    function automatic wtrs_out_t predict_answer(wtrs_in_t it);
        wtrs_out_t  r;
        logic [7:0] msk;
        int         cnt;
        r = '0;
        msk = 8'((1 << tree_width) - 1);
        case (it.operation)
            OP_APPEND: begin
                if ((int'(it.symbol) >> clamp_width(width_reg)) != 0) begin
                    r.status = ST_BAD;
                end else begin
                    // append after a build starts a fresh sequence
                    if (tree_ready) begin
                        tree_ready = 0;
                        seq_len = 0;
                    end
                    if (seq_len >= SEQ_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        seq_sym[seq_len] = it.symbol;
                        seq_len++;
                    end
                end
            end
            OP_BUILD: begin
                tree_width = clamp_width(width_reg);
                tree_ready = 1;
            end
            OP_ACCESS, OP_RANK, OP_SELECT: begin
                if (!tree_ready) begin
                    r.status = ST_NOT_BUILT;
                end else if (it.operation == OP_ACCESS) begin
                    if (it.position >= seq_len) r.status = ST_BAD;
                    else r.answer = ANSWER_W'(seq_sym[it.position] & msk);
                end else if (it.operation == OP_RANK) begin
                    if (it.position >= seq_len || (int'(it.symbol) >> tree_width) != 0) begin
                        r.status = ST_BAD;
                    end else begin
                        cnt = 0;
                        for (int i = 0; i <= it.position; i++)
                            if ((seq_sym[i] & msk) == it.symbol) cnt++;
                        r.answer = ANSWER_W'(cnt);
                    end
                end else begin
                    if (it.occurrence == 0 || (int'(it.symbol) >> tree_width) != 0) begin
                        r.status = ST_BAD;
                    end else begin
                        cnt = 0;
                        for (int i = 0; i < seq_len; i++) begin
                            if ((seq_sym[i] & msk) == it.symbol) begin
                                cnt++;
                                if (cnt == it.occurrence && !r.found) begin
                                    r.found  = 1'b1;
                                    r.answer = ANSWER_W'(i);
                                end
                            end
                        end
                    end
                end
            end
            default: r.status = ST_BAD;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check result beats, predict on input beats, watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        wtrs_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected: ", $realtime,
                                 "answer=%0d found=%0d status=%0d",
                                 m_data.answer, m_data.found, m_data.status);
                end else begin
                    want = answer_q.pop_front();
                    if (m_data.answer !== want.answer || m_data.found !== want.found ||
                        m_data.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch expected ", $realtime,
                                     "answer=%0d found=%0d status=%0d, ",
                                     want.answer, want.found, want.status,
                                     "got answer=%0d found=%0d status=%0d",
                                     m_data.answer, m_data.found, m_data.status);
                    end
                end
            end
            if (s_valid && s_ready)
                answer_q.push_back(predict_answer(s_data));
            // count cycles with no beat on either channel
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("FAIL wavelet_tree_rank_select_core");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    bit hold_request;
    int hold_left;
    int stall_left;
    int calm_left;

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 0;
            hold_left = 300;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (calm_left > 0) begin
            // stretch with no stalls
            calm_left--;
            m_ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 19))
                0:       stall_left = $urandom_range(10, 40);
                1, 2:    calm_left  = $urandom_range(20, 80);
                3, 4, 5: stall_left = $urandom_range(1, 3);
                default: ;
            endcase
            m_ready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic wtrs_in_t make_beat(logic [2:0] op, int sym, int pos, int occ);
        wtrs_in_t it;
        it.operation  = op;
        it.symbol     = 8'(sym);
        it.position   = 10'(pos);
        it.occurrence = 11'(occ);
        return it;
    endfunction

    // Offer one beat after an optional gap and hold it until accepted.
    task automatic send_beat(input wtrs_in_t it, input int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Drop valid and wait until every outstanding result has arrived.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_width(input logic [3:0] v);
        drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        width_reg = v;
    endtask

    // Query with mostly in-range operands drawn from the current sequence.
    task automatic random_query();
        int         alpha;
        int         roll;
        int         sym;
        int         pos;
        wtrs_in_t   it;
        alpha = 1 << tree_width;
        roll  = $urandom_range(0, 99);
        pos   = (seq_len > 0) ? $urandom_range(0, seq_len - 1) : 0;
        // pick a symbol that is really stored most of the time
        sym   = (seq_len > 0 && $urandom_range(0, 3) != 0)
                ? (seq_sym[pos] & (alpha - 1)) : $urandom_range(0, alpha - 1);
        if (roll < 30)
            it = make_beat(OP_ACCESS, $urandom_range(0, 255), pos, $urandom_range(0, 2047));
        else if (roll < 60)
            it = make_beat(OP_RANK, sym, pos, $urandom_range(0, 2047));
        else if (roll < 90)
            it = make_beat(OP_SELECT, sym, $urandom_range(0, 1023),
                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047)
                                                     : $urandom_range(1, 4));
        else
            it = make_beat(3'($urandom_range(0, 7)), $urandom_range(0, 255),
                           $urandom_range(0, 1023), $urandom_range(0, 2047));
        send_beat(it, pick_gap());
    endtask

    // One round of mostly legal beats: load a sequence, build, query it.
    task automatic random_round(input int max_len, input int n_queries,
                                input bit rewidth);
        int len;
        int alpha;
        len = $urandom_range(1, max_len);
        alpha = 1 << clamp_width(width_reg);
        for (int i = 0; i < len; i++) begin
            // mostly legal symbols, sometimes too wide ones
            if ($urandom_range(0, 9) == 0)
                send_beat(make_beat(OP_APPEND, $urandom_range(0, 255), $urandom_range(0, 1023),
                                    $urandom_range(0, 2047)), pick_gap());
            else
                send_beat(make_beat(OP_APPEND, $urandom_range(0, alpha - 1),
                                    $urandom_range(0, 1023), $urandom_range(0, 2047)),
                          pick_gap());
        end
        // narrowing the width before the build masks the stored symbols
        if (rewidth) write_width(4'($urandom_range(1, 7)));
        send_beat(make_beat(OP_BUILD, $urandom_range(0, 255), $urandom_range(0, 1023),
                            $urandom_range(0, 2047)), pick_gap());
        for (int q = 0; q < n_queries; q++) random_query();
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        wtrs_in_t  beat;
        bit        typed;     // expected value written in below
        wtrs_out_t want;
    } vector_t;

    function automatic vector_t row(wtrs_in_t b, bit typed, int ans, bit fnd, logic [1:0] st);
        vector_t v;
        v.beat        = b;
        v.typed       = typed;
        v.want.answer = ANSWER_W'(ans);
        v.want.found  = fnd;
        v.want.status = st;
        return v;
    endfunction

    vector_t directed[$];

    initial begin
        wtrs_out_t got;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        seq_len      = 0;
        tree_ready   = 0;
        tree_width   = 1;
        width_reg    = SYMBOL_BITS_RESET;
        mismatches   = 0;
        idle_cycles  = 0;
        hold_request = 0;
        hold_left    = 0;
        stall_left   = 0;
        calm_left    = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // queries before any build, unknown codes, empty build
        directed.push_back(row(make_beat(OP_ACCESS, 0, 0, 1), 1, 0, 0, ST_NOT_BUILT));
        directed.push_back(row(make_beat(OP_RANK, 255, 1023, 1), 1, 0, 0, ST_NOT_BUILT));
        directed.push_back(row(make_beat(OP_SELECT, 0, 0, 1024), 1, 0, 0, ST_NOT_BUILT));
        directed.push_back(row(make_beat(3'd5, 0, 0, 0), 1, 0, 0, ST_BAD));
        directed.push_back(row(make_beat(3'd7, 255, 1023, 2047), 1, 0, 0, ST_BAD));
        directed.push_back(row(make_beat(OP_BUILD, 0, 0, 0), 1, 0, 0, ST_OK));
        directed.push_back(row(make_beat(OP_ACCESS, 0, 0, 0), 1, 0, 0, ST_BAD));
        // a small sequence at full width
        directed.push_back(row(make_beat(OP_APPEND, 255, 1023, 2047), 1, 0, 0, ST_OK));
        directed.push_back(row(make_beat(OP_APPEND, 0, 0, 0), 1, 0, 0, ST_OK));
        directed.push_back(row(make_beat(OP_APPEND, 128, 0, 0), 1, 0, 0, ST_OK));
        directed.push_back(row(make_beat(OP_APPEND, 255, 0, 0), 1, 0, 0, ST_OK));
        directed.push_back(row(make_beat(OP_BUILD, 0, 0, 0), 1, 0, 0, ST_OK));
        directed.push_back(row(make_beat(OP_ACCESS, 0, 0, 0), 1, 255, 0, ST_OK));
        directed.push_back(row(make_beat(OP_ACCESS, 0, 2, 0), 1, 128, 0, ST_OK));
        directed.push_back(row(make_beat(OP_ACCESS, 0, 4, 0), 1, 0, 0, ST_BAD));
        directed.push_back(row(make_beat(OP_RANK, 255, 3, 0), 1, 2, 0, ST_OK));
        directed.push_back(row(make_beat(OP_SELECT, 255, 0, 2), 1, 3, 1, ST_OK));
        directed.push_back(row(make_beat(OP_SELECT, 0, 0, 2), 1, 0, 0, ST_OK));
        directed.push_back(row(make_beat(OP_SELECT, 0, 0, 0), 1, 0, 0, ST_BAD));
        directed.push_back(row(make_beat(OP_SELECT, 7, 0, 1024), 0, 0, 0, ST_OK));
        directed.push_back(row(make_beat(OP_BUILD, 0, 0, 0), 1, 0, 0, ST_OK));
        // append after build starts over
        directed.push_back(row(make_beat(OP_APPEND, 7, 0, 0), 1, 0, 0, ST_OK));
        directed.push_back(row(make_beat(OP_BUILD, 0, 0, 0), 1, 0, 0, ST_OK));
        directed.push_back(row(make_beat(OP_ACCESS, 0, 0, 0), 1, 7, 0, ST_OK));
        directed.push_back(row(make_beat(OP_RANK, 7, 1, 0), 1, 0, 0, ST_BAD));

        foreach (directed[i]) begin
            send_beat(directed[i].beat, pick_gap());
            // let the monitor queue the prediction for this beat first
            #1;
            // typed expectations must also agree with the predictor
            if (directed[i].typed) begin
                got = answer_q[answer_q.size() - 1];
                if (got != directed[i].want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row %0d: table says answer=%0d found=%0d status=%0d, ",
                                 i, directed[i].want.answer, directed[i].want.found,
                                 directed[i].want.status,
                                 "predictor %0d/%0d/%0d", got.answer, got.found, got.status);
                end
            end
        end

        // narrow widths, clamped register values, symbol-too-wide appends
        write_width(4'd1);
        random_round(12, 6, 0);
        write_width(4'd0);
        random_round(12, 6, 0);
        write_width(4'd15);
        random_round(20, 8, 0);

        // a longer sequence at full width
        write_width(4'd8);
        random_round(40, 8, 0);

        // long hold on the result side while beats keep coming
        write_width(4'd3);
        hold_request = 1;
        random_round(16, 10, 0);

        // sender pause until everything is back
        drain();
        write_width(4'd4);
        random_round(30, 10, 1);
        write_width(4'd2);
        random_round(16, 10, 0);
        write_width(4'd5);
        random_round(30, 12, 0);

        // bulk of the random traffic with varying widths
        for (int ph = 0; ph < 5; ph++) begin
            write_width(4'($urandom_range(0, 15)));
            for (int r = 0; r < 2; r++)
                random_round(($urandom_range(0, 7) == 0) ? 200 : 20, 8,
                             ($urandom_range(0, 5) == 0));
        end
        write_width(4'd8);
        random_round(20, 10, 0);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS wavelet_tree_rank_select_core");
        else
            $display("FAIL wavelet_tree_rank_select_core");
        $finish;
    end

endmodule
`default_nettype wire
